// File: design/pcode_constant_fold_alu_defines.svh
// assertion macros for the constant fold alu
// no dependencies; included by pcode_constant_fold_alu.sv
`ifndef PCODE_CONSTANT_FOLD_ALU_DEFINES_SVH
`define PCODE_CONSTANT_FOLD_ALU_DEFINES_SVH

// same-cycle implication
`define PCFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/pcfa_pkg.sv
// opcode codes and shared constants of the constant fold alu
// no dependencies
package pcfa_pkg;

   typedef logic [4:0] op_type;
   typedef logic [3:0] size_type;

   localparam op_type OP_ADD    = 5'd0;
   localparam op_type OP_SUB    = 5'd1;
   localparam op_type OP_MUL    = 5'd2;
   localparam op_type OP_DIVU   = 5'd3;
   localparam op_type OP_DIVS   = 5'd4;
   localparam op_type OP_REMU   = 5'd5;
   localparam op_type OP_REMS   = 5'd6;
   localparam op_type OP_AND    = 5'd7;
   localparam op_type OP_OR     = 5'd8;
   localparam op_type OP_XOR    = 5'd9;
   localparam op_type OP_SHL    = 5'd10;
   localparam op_type OP_SHR    = 5'd11;
   localparam op_type OP_SAR    = 5'd12;
   localparam op_type OP_EQ     = 5'd13;
   localparam op_type OP_NE     = 5'd14;
   localparam op_type OP_ULT    = 5'd15;
   localparam op_type OP_ULE    = 5'd16;
   localparam op_type OP_SLT    = 5'd17;
   localparam op_type OP_SLE    = 5'd18;
   localparam op_type OP_NOT    = 5'd19;
   localparam op_type OP_NEG    = 5'd20;
   localparam op_type OP_LNOT   = 5'd21;
   localparam op_type OP_LAND   = 5'd22;
   localparam op_type OP_LOR    = 5'd23;
   localparam op_type OP_ZEXT   = 5'd24;

   localparam size_type ZEXT_FULL_BYTES = 4'd8;
   localparam int       SHIFT_BITS      = 6;

endpackage

// File: design/pcode_constant_fold_alu.sv
// constant fold alu: start flows via stage 1, stage 2, divider and output stage to rsp_valid
// throughput one transaction per cycle; busy stays low, the receiver cannot stall
// the divider is a chain of DATA_WIDTH restoring steps, one stage per quotient bit
// the multiplier uses half-width partial products summed one stage later
// synchronous active-high reset clears all valid bits; payload registers are not reset
`include "pcode_constant_fold_alu_defines.svh"

module pcode_constant_fold_alu #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  pcfa_pkg::op_type        req_action,
   input  logic [DATA_WIDTH-1:0]   req_operand_a,
   input  logic [DATA_WIDTH-1:0]   req_operand_b,
   input  pcfa_pkg::size_type      req_size_bytes,
   output logic                    rsp_valid,
   output logic [DATA_WIDTH-1:0]   rsp_value,
   output logic                    rsp_folded
);
   import pcfa_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int H   = (DATA_WIDTH + 1) / 2;
   localparam int LAT = DATA_WIDTH + 3;

   // stage 1: input capture
   logic         s1_vld_ff;
   op_type       s1_op_ff;
   logic [W-1:0] s1_a_ff, s1_b_ff;
   size_type     s1_sz_ff;

   // stage 2: simple ops, partial products, divider setup
   logic         s2_vld_ff;
   op_type       s2_op_ff;
   logic [W-1:0] s2_res_ff, s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_num_ff, s2_den_ff;
   logic         s2_negq_ff, s2_negr_ff;
   logic [W-1:0] s2_res_in, s2_num_in, s2_den_in;
   logic         s2_negq_in, s2_negr_in;

   // divider stages
   logic         dv_vld_ff  [W];
   op_type       dv_op_ff   [W];
   logic [W-1:0] dv_res_ff  [W];
   logic [W-1:0] dv_rem_ff  [W];
   logic [W-1:0] dv_quo_ff  [W];
   logic [W-1:0] dv_den_ff  [W];
   logic         dv_negq_ff [W];
   logic         dv_negr_ff [W];
   logic [W-1:0] dv_res_in  [W];
   logic [W-1:0] dv_rem_in  [W];
   logic [W-1:0] dv_quo_in  [W];
   logic [W-1:0] dv_den_in  [W];

   // output stage
   logic         out_vld_ff;
   op_type       out_op_ff;
   logic [W-1:0] out_val_ff, out_val_in;
   logic         out_fold_ff;

   logic [W-1:0]            mul_sum;
   logic [SHIFT_BITS-1:0]   sh;
   size_type                zn;
   logic [63:0]             zmask64;
   logic                    a_zero, b_zero;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start;
      end
      s1_op_ff <= req_action;
      s1_a_ff  <= req_operand_a;
      s1_b_ff  <= req_operand_b;
      s1_sz_ff <= req_size_bytes;
   end

   always_comb begin
      sh      = s1_b_ff[SHIFT_BITS-1:0];
      a_zero  = (s1_a_ff == '0);
      b_zero  = (s1_b_ff == '0);
      zn      = (s1_sz_ff == '0) ? size_type'(1) : s1_sz_ff;
      zmask64 = (zn >= ZEXT_FULL_BYTES) ? '1
              : ((64'd1 << {zn[2:0], 3'b000}) - 64'd1);
      case (s1_op_ff)
         OP_ADD:  s2_res_in = s1_a_ff + s1_b_ff;
         OP_SUB:  s2_res_in = s1_a_ff - s1_b_ff;
         OP_AND:  s2_res_in = s1_a_ff & s1_b_ff;
         OP_OR:   s2_res_in = s1_a_ff | s1_b_ff;
         OP_XOR:  s2_res_in = s1_a_ff ^ s1_b_ff;
         OP_SHL:  s2_res_in = s1_a_ff << sh;
         OP_SHR:  s2_res_in = s1_a_ff >> sh;
         OP_SAR:  s2_res_in = W'($signed(s1_a_ff) >>> sh);
         OP_EQ:   s2_res_in = W'(s1_a_ff == s1_b_ff);
         OP_NE:   s2_res_in = W'(s1_a_ff != s1_b_ff);
         OP_ULT:  s2_res_in = W'(s1_a_ff < s1_b_ff);
         OP_ULE:  s2_res_in = W'(s1_a_ff <= s1_b_ff);
         OP_SLT:  s2_res_in = W'($signed(s1_a_ff) < $signed(s1_b_ff));
         OP_SLE:  s2_res_in = W'($signed(s1_a_ff) <= $signed(s1_b_ff));
         OP_NOT:  s2_res_in = ~s1_a_ff;
         OP_NEG:  s2_res_in = '0 - s1_a_ff;
         OP_LNOT: s2_res_in = W'(a_zero);
         OP_LAND: s2_res_in = W'(!a_zero && !b_zero);
         OP_LOR:  s2_res_in = W'(!a_zero || !b_zero);
         OP_ZEXT: s2_res_in = s1_a_ff & zmask64[W-1:0];
         default: s2_res_in = '0;
      endcase
      s2_negq_in = (s1_op_ff == OP_DIVS) && (s1_a_ff[W-1] ^ s1_b_ff[W-1]);
      s2_negr_in = (s1_op_ff == OP_REMS) && s1_a_ff[W-1];
      if ((s1_op_ff == OP_DIVS) || (s1_op_ff == OP_REMS)) begin
         s2_num_in = s1_a_ff[W-1] ? ('0 - s1_a_ff) : s1_a_ff;
         s2_den_in = s1_b_ff[W-1] ? ('0 - s1_b_ff) : s1_b_ff;
      end else begin
         s2_num_in = s1_a_ff;
         s2_den_in = s1_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_op_ff   <= s1_op_ff;
      s2_res_ff  <= s2_res_in;
      s2_p0_ff   <= W'(s1_a_ff[H-1:0]) * W'(s1_b_ff[H-1:0]);
      s2_p1_ff   <= W'(s1_a_ff[H-1:0]) * W'(s1_b_ff[W-1:H]);
      s2_p2_ff   <= W'(s1_a_ff[W-1:H]) * W'(s1_b_ff[H-1:0]);
      s2_num_ff  <= s2_num_in;
      s2_den_ff  <= s2_den_in;
      s2_negq_ff <= s2_negq_in;
      s2_negr_ff <= s2_negr_in;
   end

   assign mul_sum = s2_p0_ff + ((s2_p1_ff + s2_p2_ff) << H);

   always_comb begin
      logic [W-1:0] r_src, q_src, d_src;
      logic [W:0]   trial;
      for (int k = 0; k < W; k++) begin
         if (k == 0) begin
            r_src        = '0;
            q_src        = s2_num_ff;
            d_src        = s2_den_ff;
            dv_res_in[k] = (s2_op_ff == OP_MUL) ? mul_sum : s2_res_ff;
         end else begin
            r_src        = dv_rem_ff[k-1];
            q_src        = dv_quo_ff[k-1];
            d_src        = dv_den_ff[k-1];
            dv_res_in[k] = dv_res_ff[k-1];
         end
         trial = {r_src, q_src[W-1]};
         if (trial >= {1'b0, d_src}) begin
            dv_rem_in[k] = W'(trial - {1'b0, d_src});
            dv_quo_in[k] = {q_src[W-2:0], 1'b1};
         end else begin
            dv_rem_in[k] = trial[W-1:0];
            dv_quo_in[k] = {q_src[W-2:0], 1'b0};
         end
         dv_den_in[k] = d_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < W; k++) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else begin
            dv_vld_ff[k] <= (k == 0) ? s2_vld_ff : dv_vld_ff[k-1];
         end
         dv_op_ff[k]   <= (k == 0) ? s2_op_ff   : dv_op_ff[k-1];
         dv_negq_ff[k] <= (k == 0) ? s2_negq_ff : dv_negq_ff[k-1];
         dv_negr_ff[k] <= (k == 0) ? s2_negr_ff : dv_negr_ff[k-1];
         dv_res_ff[k]  <= dv_res_in[k];
         dv_rem_ff[k]  <= dv_rem_in[k];
         dv_quo_ff[k]  <= dv_quo_in[k];
         dv_den_ff[k]  <= dv_den_in[k];
      end
   end

   always_comb begin
      logic         den_zero;
      logic [W-1:0] qv, rv;
      den_zero = (dv_den_ff[W-1] == '0);
      qv = dv_negq_ff[W-1] ? ('0 - dv_quo_ff[W-1]) : dv_quo_ff[W-1];
      rv = dv_negr_ff[W-1] ? ('0 - dv_rem_ff[W-1]) : dv_rem_ff[W-1];
      case (dv_op_ff[W-1])
         OP_DIVU, OP_DIVS: out_val_in = den_zero ? '0 : qv;
         OP_REMU, OP_REMS: out_val_in = den_zero ? '0 : rv;
         default:          out_val_in = dv_res_ff[W-1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld_ff[W-1];
      end
      out_op_ff   <= dv_op_ff[W-1];
      out_val_ff  <= out_val_in;
      out_fold_ff <= (dv_op_ff[W-1] <= OP_ZEXT);
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_value  = out_val_ff;
   assign rsp_folded = out_fold_ff;

   `PCFA_ASSERT_NOW(a_unfolded_zero, clock, reset, rsp_valid && !rsp_folded, rsp_value == '0, "unfolded result is not zero")
   `PCFA_ASSERT_NOW(a_fixed_latency, clock, reset, rsp_valid, $past(start, LAT), "result without a matching start")
   `PCFA_ASSERT_NOW(a_compare_bool, clock, reset, rsp_valid && (out_op_ff == OP_EQ || out_op_ff == OP_NE || out_op_ff == OP_ULT || out_op_ff == OP_ULE || out_op_ff == OP_SLT || out_op_ff == OP_SLE), rsp_value[W-1:1] == '0, "compare result is not boolean")
   `PCFA_ASSERT_NEXT(a_div_to_out, clock, reset, dv_vld_ff[W-1], out_vld_ff, "divider output lost")

endmodule
